// File: rtl/core/bgpop_pkg.sv
package bgpop_pkg;

    // header layout and protocol constants
    localparam logic [11:0] HEADER_LEN      = 12'd10;
    localparam logic [7:0]  CAPA_PARAM_TYPE = 8'd2;
    localparam logic [7:0]  ASN4_CODE       = 8'd65;
    localparam logic [7:0]  ASN4_LEN        = 8'd4;
    localparam logic [31:0] ASN_TRANSITION  = 32'd23456;
    localparam logic [31:0] ASN_LIMIT       = 32'h0000_ffff;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_LEN    = 3'd1;
    localparam logic [2:0] ST_UNSPEC = 3'd2;
    localparam logic [2:0] ST_OPT    = 3'd3;
    localparam logic [2:0] ST_TRAIL  = 3'd4;

    // one input item as held in the input register
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] msg_length;
        logic        last;
    } t_item;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  error_data;
        logic [7:0]  version;
        logic [31:0] peer_asn;
        logic [15:0] hold_secs;
        logic [31:0] router_id;
        logic        four_byte_asn;
        logic [8:0]  parsed_length;
    } t_result;

endpackage

// File: rtl/core/bgp_open_message_parser.sv
// channel   dir  tdata fields (low bit up)                               tlast
// s_axis    in   data_byte[7:0] msg_length[19:8] zero[23:20]             last
// m_axis    out  status[2:0] error_data[10:3] version[18:11]             -
//                peer_asn[50:19] hold_secs[66:51] router_id[98:67]
//                four_byte_asn[99] parsed_length[108:100] zero[111:109]
//
// one input item per cycle unless a last item is held back by a stalled output;
// an item waits in the input register and is parsed against the state while there
// a result appears in the output register in the cycle after its last item is parsed
// reset is synchronous and active low; the parse restarts after each last item
// a stalled output holds back only an input item marked last
module bgp_open_message_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // data_byte, msg_length, zero fill
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata    // status, error_data, version, peer_asn,
                                           // hold_secs, router_id, four_byte_asn,
                                           // parsed_length, zero fill
);

    logic               r_in_valid;
    bgpop_pkg::t_item   r_in;
    logic               r_out_valid;
    bgpop_pkg::t_result r_out;
    bgpop_pkg::t_result w_res;
    logic               w_out_free;
    logic               w_fire;

    // handshake between input stage, parser and output register
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && (!r_in.last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.data_byte  <= i_s_axis_tdata[7:0];
            r_in.msg_length <= i_s_axis_tdata[19:8];
            r_in.last       <= i_s_axis_tlast;
        end
    end

    // parser
    bgpop_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.parsed_length, r_out.four_byte_asn,
                              r_out.router_id, r_out.hold_secs, r_out.peer_asn,
                              r_out.version, r_out.error_data, r_out.status};

    // a parsed last item always shows up on the output next cycle
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last) |=> o_m_axis_tvalid)
        else $error("result lost after last item");

    // a last item never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !(w_fire && r_in.last))
        else $error("pending result overwritten");

    // parsed length is reported only for a good message
    a_len_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != bgpop_pkg::ST_OK) |-> (r_out.parsed_length == 9'd0))
        else $error("parsed length on failed message");

endmodule

// File: rtl/core/bgpop_engine.sv
module bgpop_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bgpop_pkg::t_item  i_item,
    output bgpop_pkg::t_result o_res
);

    // parse phases
    localparam logic [3:0] PH_HDR   = 4'd0;
    localparam logic [3:0] PH_PTYPE = 4'd1;
    localparam logic [3:0] PH_PLEN  = 4'd2;
    localparam logic [3:0] PH_CCODE = 4'd3;
    localparam logic [3:0] PH_CLEN  = 4'd4;
    localparam logic [3:0] PH_CASN  = 4'd5;
    localparam logic [3:0] PH_CSKIP = 4'd6;
    localparam logic [3:0] PH_DONE  = 4'd7;
    localparam logic [3:0] PH_ERR   = 4'd8;

    logic [3:0]  r_cnt,        n_cnt;
    logic [3:0]  r_phase,      n_phase;
    logic [7:0]  r_opt_total,  n_opt_total;
    logic [8:0]  r_opt_left,   n_opt_left;
    logic [7:0]  r_param_left, n_param_left;
    logic [7:0]  r_capa_left,  n_capa_left;
    logic [7:0]  r_code,       n_code;
    logic [31:0] r_field,      n_field;
    logic [31:0] r_asn,        n_asn;
    logic [15:0] r_hold,       n_hold;
    logic [31:0] r_id,         n_id;
    logic [7:0]  r_version,    n_version;
    logic        r_four,       n_four;
    logic [2:0]  r_err,        n_err;

    // first error wins, phase always drops to error
    function automatic logic [2:0] f_fail(input logic [2:0] err, input logic [2:0] code);
        f_fail = (err == bgpop_pkg::ST_OK) ? code : err;
    endfunction

    // next state and result for the item in the input register
    always_comb begin
        logic [7:0]  v_b;
        logic [11:0] v_len;
        logic [2:0]  v_st;
        logic [7:0]  v_pl;
        logic [8:0]  v_ol;

        v_b   = i_item.data_byte;
        v_len = i_item.msg_length;
        v_st  = bgpop_pkg::ST_OK;
        v_pl  = '0;
        v_ol  = '0;

        n_cnt        = r_cnt;
        n_phase      = r_phase;
        n_opt_total  = r_opt_total;
        n_opt_left   = r_opt_left;
        n_param_left = r_param_left;
        n_capa_left  = r_capa_left;
        n_code       = r_code;
        n_field      = r_field;
        n_asn        = r_asn;
        n_hold       = r_hold;
        n_id         = r_id;
        n_version    = r_version;
        n_four       = r_four;
        n_err        = r_err;

        if (i_fire) begin
            // short message length
            if (r_err == bgpop_pkg::ST_OK && v_len < bgpop_pkg::HEADER_LEN) begin
                n_err   = bgpop_pkg::ST_LEN;
                n_phase = PH_ERR;
            end

            case (n_phase)
                PH_HDR: begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd0) begin
                        n_version = v_b;
                    end else if (r_cnt <= 4'd2) begin
                        n_asn = {16'd0, r_asn[7:0], v_b};
                    end else if (r_cnt <= 4'd4) begin
                        n_hold = {r_hold[7:0], v_b};
                    end else if (r_cnt <= 4'd8) begin
                        n_id = {r_id[23:0], v_b};
                    end else begin
                        n_opt_total = v_b;
                        if ({4'd0, v_b} != (v_len - bgpop_pkg::HEADER_LEN) || v_b < 8'd2) begin
                            n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                            n_phase = PH_ERR;
                        end else begin
                            n_opt_left = {1'b0, v_b};
                            n_phase    = PH_PTYPE;
                        end
                    end
                end
                PH_PTYPE: begin
                    n_code     = v_b;
                    n_opt_left = r_opt_left - 9'd1;
                    n_phase    = PH_PLEN;
                end
                PH_PLEN: begin
                    n_opt_left = r_opt_left - 9'd1;
                    if ({1'b0, v_b} > n_opt_left) begin
                        n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                        n_phase = PH_ERR;
                    end else if (r_code != bgpop_pkg::CAPA_PARAM_TYPE) begin
                        n_err   = f_fail(n_err, bgpop_pkg::ST_OPT);
                        n_phase = PH_ERR;
                    end else if (v_b < 8'd2) begin
                        n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                        n_phase = PH_ERR;
                    end else begin
                        n_param_left = v_b;
                        n_opt_left   = n_opt_left - {1'b0, v_b};
                        n_phase      = PH_CCODE;
                    end
                end
                PH_CCODE: begin
                    n_code       = v_b;
                    n_param_left = r_param_left - 8'd1;
                    n_phase      = PH_CLEN;
                end
                PH_CLEN: begin
                    n_param_left = r_param_left - 8'd1;
                    if (v_b > n_param_left) begin
                        n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                        n_phase = PH_ERR;
                    end else if (r_code == bgpop_pkg::ASN4_CODE) begin
                        n_four = 1'b1;
                        if (v_b != bgpop_pkg::ASN4_LEN) begin
                            n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                            n_phase = PH_ERR;
                        end else begin
                            n_capa_left  = bgpop_pkg::ASN4_LEN;
                            n_field      = '0;
                            n_param_left = n_param_left - v_b;
                            n_phase      = PH_CASN;
                        end
                    end else begin
                        n_param_left = n_param_left - v_b;
                        n_capa_left  = v_b;
                        n_phase      = PH_CSKIP;
                        // empty capability closes at once
                        if (v_b == 8'd0) begin
                            v_pl = n_param_left;
                            v_ol = n_opt_left;
                            if (v_pl == 8'd0) begin
                                if (v_ol == 9'd0) begin
                                    n_phase = PH_DONE;
                                end else if (v_ol < 9'd2) begin
                                    n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                                    n_phase = PH_ERR;
                                end else begin
                                    n_phase = PH_PTYPE;
                                end
                            end else if (v_pl < 8'd2) begin
                                n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                                n_phase = PH_ERR;
                            end else begin
                                n_phase = PH_CCODE;
                            end
                        end
                    end
                end
                PH_CASN, PH_CSKIP: begin
                    n_capa_left = r_capa_left - 8'd1;
                    if (n_phase == PH_CASN) begin
                        n_field = {r_field[23:0], v_b};
                    end
                    if (n_capa_left == 8'd0) begin
                        if (n_phase == PH_CASN && n_field >= bgpop_pkg::ASN_LIMIT
                                && r_asn != bgpop_pkg::ASN_TRANSITION) begin
                            n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                            n_phase = PH_ERR;
                        end else begin
                            if (n_phase == PH_CASN) begin
                                n_asn = n_field;
                            end
                            // capability closed: next capability or parameter
                            v_pl = r_param_left;
                            v_ol = r_opt_left;
                            if (v_pl == 8'd0) begin
                                if (v_ol == 9'd0) begin
                                    n_phase = PH_DONE;
                                end else if (v_ol < 9'd2) begin
                                    n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                                    n_phase = PH_ERR;
                                end else begin
                                    n_phase = PH_PTYPE;
                                end
                            end else if (v_pl < 8'd2) begin
                                n_err   = f_fail(n_err, bgpop_pkg::ST_UNSPEC);
                                n_phase = PH_ERR;
                            end else begin
                                n_phase = PH_CCODE;
                            end
                        end
                    end
                end
                PH_DONE: begin
                    n_err   = f_fail(n_err, bgpop_pkg::ST_TRAIL);
                    n_phase = PH_ERR;
                end
                default: begin
                end
            endcase
        end

        // result fields from the updated state
        v_st = n_err;
        if (v_st == bgpop_pkg::ST_OK && n_phase != PH_DONE) begin
            v_st = bgpop_pkg::ST_TRAIL;
        end
        o_res.status        = v_st;
        o_res.error_data    = (v_st == bgpop_pkg::ST_LEN) ? v_len[7:0] : 8'd0;
        o_res.version       = n_version;
        o_res.peer_asn      = n_asn;
        o_res.hold_secs     = n_hold;
        o_res.router_id     = n_id;
        o_res.four_byte_asn = n_four;
        o_res.parsed_length = (v_st == bgpop_pkg::ST_OK)
                              ? ({1'b0, n_opt_total} + 9'd10) : 9'd0;

        // end of message: back to the start state
        if (i_fire && i_item.last) begin
            n_cnt        = '0;
            n_phase      = PH_HDR;
            n_opt_total  = '0;
            n_opt_left   = '0;
            n_param_left = '0;
            n_capa_left  = '0;
            n_code       = '0;
            n_field      = '0;
            n_asn        = '0;
            n_hold       = '0;
            n_id         = '0;
            n_version    = '0;
            n_four       = 1'b0;
            n_err        = bgpop_pkg::ST_OK;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_phase      <= PH_HDR;
            r_opt_total  <= '0;
            r_opt_left   <= '0;
            r_param_left <= '0;
            r_capa_left  <= '0;
            r_code       <= '0;
            r_field      <= '0;
            r_asn        <= '0;
            r_hold       <= '0;
            r_id         <= '0;
            r_version    <= '0;
            r_four       <= 1'b0;
            r_err        <= bgpop_pkg::ST_OK;
        end else begin
            r_cnt        <= n_cnt;
            r_phase      <= n_phase;
            r_opt_total  <= n_opt_total;
            r_opt_left   <= n_opt_left;
            r_param_left <= n_param_left;
            r_capa_left  <= n_capa_left;
            r_code       <= n_code;
            r_field      <= n_field;
            r_asn        <= n_asn;
            r_hold       <= n_hold;
            r_id         <= n_id;
            r_version    <= n_version;
            r_four       <= n_four;
            r_err        <= n_err;
        end
    end

    // a latched error always parks the parser
    a_err_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != bgpop_pkg::ST_OK) |-> (r_phase == PH_ERR))
        else $error("error latched outside error phase");

    // header counter never runs past the length byte while in the header
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_cnt <= 4'd9))
        else $error("header counter overran");

    // end of message restarts the parse
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last) |=> (r_phase == PH_HDR && r_cnt == 4'd0
                                     && r_err == bgpop_pkg::ST_OK))
        else $error("parser not restarted after last item");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bgpop_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [7:0]  SKIP_CODE      = 8'd7;

    // parse phases of the predictor
    typedef enum logic [3:0] {
        PH_HEADER, PH_PARAM_TYPE, PH_PARAM_LEN, PH_CAPA_CODE, PH_CAPA_LEN,
        PH_CAPA_ASN, PH_CAPA_SKIP, PH_COMPLETE, PH_FAILED
    } t_parse_phase;

    // predicts the parse result of each message and checks the block's output
    class open_result_board;
        logic [11:0]  byte_count;
        t_parse_phase phase;
        logic [7:0]   opt_total;
        logic [8:0]   opt_left;
        logic [7:0]   param_left;
        logic [7:0]   capa_left;
        logic [7:0]   code_held;
        logic [31:0]  asn_shift;
        logic [31:0]  asn_held;
        logic [15:0]  hold_held;
        logic [31:0]  id_held;
        logic [7:0]   version_held;
        logic         four_flag;
        logic [2:0]   err_code;
        t_result      pending_results[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            byte_count   = '0;
            phase        = PH_HEADER;
            opt_total    = '0;
            opt_left     = '0;
            param_left   = '0;
            capa_left    = '0;
            code_held    = '0;
            asn_shift    = '0;
            asn_held     = '0;
            hold_held    = '0;
            id_held      = '0;
            version_held = '0;
            four_flag    = 1'b0;
            err_code     = ST_OK;
        endfunction

        // only the first error is kept
        function void fail(logic [2:0] code);
            if (err_code == ST_OK) begin
                err_code = code;
            end
            phase = PH_FAILED;
        endfunction

        function void after_param();
            if (opt_left == 0) begin
                phase = PH_COMPLETE;
            end else if (opt_left < 2) begin
                fail(ST_UNSPEC);
            end else begin
                phase = PH_PARAM_TYPE;
            end
        endfunction

        function void after_capa();
            if (param_left == 0) begin
                after_param();
            end else if (param_left < 2) begin
                fail(ST_UNSPEC);
            end else begin
                phase = PH_CAPA_CODE;
            end
        endfunction

        function void parse_byte(logic [7:0] b, logic [11:0] len);
            case (phase)
                PH_HEADER: begin
                    if (byte_count == 0) begin
                        version_held = b;
                    end else if (byte_count <= 2) begin
                        asn_held = {16'h0, asn_held[7:0], b};
                    end else if (byte_count <= 4) begin
                        hold_held = {hold_held[7:0], b};
                    end else if (byte_count <= 8) begin
                        id_held = {id_held[23:0], b};
                    end else begin
                        opt_total = b;
                        if ({4'h0, b} != len - HEADER_LEN || b < 2) begin
                            fail(ST_UNSPEC);
                        end else begin
                            opt_left = {1'b0, b};
                            phase    = PH_PARAM_TYPE;
                        end
                    end
                end
                PH_PARAM_TYPE: begin
                    code_held = b;
                    opt_left  = opt_left - 9'd1;
                    phase     = PH_PARAM_LEN;
                end
                PH_PARAM_LEN: begin
                    opt_left = opt_left - 9'd1;
                    if ({1'b0, b} > opt_left) begin
                        fail(ST_UNSPEC);
                    end else if (code_held != CAPA_PARAM_TYPE) begin
                        fail(ST_OPT);
                    end else if (b < 2) begin
                        fail(ST_UNSPEC);
                    end else begin
                        param_left = b;
                        opt_left   = opt_left - {1'b0, b};
                        phase      = PH_CAPA_CODE;
                    end
                end
                PH_CAPA_CODE: begin
                    code_held  = b;
                    param_left = param_left - 8'd1;
                    phase      = PH_CAPA_LEN;
                end
                PH_CAPA_LEN: begin
                    param_left = param_left - 8'd1;
                    if (b > param_left) begin
                        fail(ST_UNSPEC);
                    end else if (code_held == ASN4_CODE) begin
                        four_flag = 1'b1;
                        if (b != ASN4_LEN) begin
                            fail(ST_UNSPEC);
                        end else begin
                            capa_left  = ASN4_LEN;
                            asn_shift  = '0;
                            param_left = param_left - b;
                            phase      = PH_CAPA_ASN;
                        end
                    end else begin
                        param_left = param_left - b;
                        capa_left  = b;
                        if (b == 0) begin
                            after_capa();
                        end else begin
                            phase = PH_CAPA_SKIP;
                        end
                    end
                end
                PH_CAPA_ASN: begin
                    asn_shift = {asn_shift[23:0], b};
                    capa_left = capa_left - 8'd1;
                    if (capa_left == 0) begin
                        // large asn only allowed behind the transition asn
                        if (asn_shift >= ASN_LIMIT && asn_held != ASN_TRANSITION) begin
                            fail(ST_UNSPEC);
                        end else begin
                            asn_held = asn_shift;
                            after_capa();
                        end
                    end
                end
                PH_CAPA_SKIP: begin
                    capa_left = capa_left - 8'd1;
                    if (capa_left == 0) begin
                        after_capa();
                    end
                end
                PH_COMPLETE: begin
                    fail(ST_TRAIL);
                end
                default: begin
                end
            endcase
        endfunction

        // one accepted input item; a result is expected on the last item
        function void note_byte(logic [7:0] b, logic [11:0] len, logic is_last);
            t_result want;
            if (err_code == ST_OK && len < HEADER_LEN) begin
                fail(ST_LEN);
            end
            parse_byte(b, len);
            if (byte_count != 12'hfff) begin
                byte_count = byte_count + 12'd1;
            end
            if (is_last) begin
                want.status = err_code;
                if (want.status == ST_OK && phase != PH_COMPLETE) begin
                    want.status = ST_TRAIL;
                end
                want.error_data    = (want.status == ST_LEN) ? len[7:0] : 8'h00;
                want.version       = version_held;
                want.peer_asn      = asn_held;
                want.hold_secs     = hold_held;
                want.router_id     = id_held;
                want.four_byte_asn = four_flag;
                want.parsed_length = (want.status == ST_OK) ? 9'(opt_total) + 9'd10 : 9'd0;
                pending_results = {pending_results, want};
                clear_state();
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report(name, got, want);
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result, status", 32'(got.status), 32'h0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("error_data", 32'(got.error_data), 32'(want.error_data));
                check_field("version", 32'(got.version), 32'(want.version));
                check_field("peer_asn", got.peer_asn, want.peer_asn);
                check_field("hold_secs", 32'(got.hold_secs), 32'(want.hold_secs));
                check_field("router_id", got.router_id, want.router_id);
                check_field("four_byte_asn", 32'(got.four_byte_asn),
                            32'(want.four_byte_asn));
                check_field("parsed_length", 32'(got.parsed_length),
                            32'(want.parsed_length));
            end
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [23:0]  i_s_axis_tdata = '0;    // data_byte, msg_length, zero fill
    logic         i_s_axis_tlast = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [111:0] o_m_axis_tdata;         // status, error_data, version, peer_asn,
                                          // hold_secs, router_id, four_byte_asn,
                                          // parsed_length, zero fill

    open_result_board board = new();
    logic [7:0]       body_q[$];
    logic [11:0]      body_len;
    bit               quiet = 1'b0;
    int unsigned      bytes_sent = 0;
    int unsigned      msgs_sent = 0;
    int unsigned      rx_hold = 0;
    int unsigned      idle_cycles = 0;
    t_result          got_result;

    bgp_open_message_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_hold = idle_len();
            end
        end
    end

    // monitor both channels, predict, check and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                board.note_byte(i_s_axis_tdata[7:0], i_s_axis_tdata[19:8], i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_result.status        = o_m_axis_tdata[2:0];
                got_result.error_data    = o_m_axis_tdata[10:3];
                got_result.version       = o_m_axis_tdata[18:11];
                got_result.peer_asn      = o_m_axis_tdata[50:19];
                got_result.hold_secs     = o_m_axis_tdata[66:51];
                got_result.router_id     = o_m_axis_tdata[98:67];
                got_result.four_byte_asn = o_m_axis_tdata[99];
                got_result.parsed_length = o_m_axis_tdata[108:100];
                board.check_result(got_result);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [11:0] len, input logic is_last);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'h0, len, b};
        i_s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // whole message, last mark on its final item
    task automatic send_body(input logic [11:0] len, input bit vary_len);
        logic [11:0] item_len;
        for (int i = 0; i < body_q.size(); i++) begin
            item_len = vary_len ? 12'($urandom) : len;
            send_byte(body_q[i], item_len, i == body_q.size() - 1);
        end
        bytes_sent += body_q.size();
        msgs_sent++;
    endtask

    // hold the sender until every expected result is out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_header(input logic [7:0] ver, input logic [15:0] asn2,
                              input logic [15:0] hold, input logic [31:0] ident,
                              input logic [7:0] opt_len);
        body_q = {ver, asn2[15:8], asn2[7:0], hold[15:8], hold[7:0],
                  ident[31:24], ident[23:16], ident[15:8], ident[7:0], opt_len};
        body_len = HEADER_LEN + 12'(opt_len);
    endtask

    // well-formed message with random parameters and capabilities, but a random four-byte asn may be refused
    task automatic build_open(input int unsigned opt_cap);
        logic [7:0]  opts[$];
        logic [7:0]  caps[$];
        logic [31:0] asn4;
        logic [15:0] asn2;
        logic [7:0]  code;
        int unsigned nparam;
        int unsigned ncapa;
        int unsigned clen;
        opts   = {};
        nparam = $urandom_range(1, 3);
        for (int p = 0; p < nparam; p++) begin
            caps  = {};
            ncapa = $urandom_range(1, 3);
            for (int c = 0; c < ncapa; c++) begin
                if (opt_cap > 100 && p == 0 && c == 0) begin
                    // one long skipped capability for big messages
                    clen = $urandom_range(40, opt_cap - 4);
                    caps = {caps, SKIP_CODE, 8'(clen)};
                    repeat (clen) caps = {caps, 8'($urandom)};
                end else if ($urandom_range(0, 9) < 4) begin
                    asn4 = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 65534);
                    caps = {caps, ASN4_CODE, ASN4_LEN, asn4[31:24], asn4[23:16],
                            asn4[15:8], asn4[7:0]};
                end else begin
                    code = 8'($urandom);
                    if (code == ASN4_CODE) begin
                        code = SKIP_CODE;
                    end
                    clen = $urandom_range(0, 6);
                    caps = {caps, code, 8'(clen)};
                    repeat (clen) caps = {caps, 8'($urandom)};
                end
            end
            if (opts.size() + caps.size() + 2 > opt_cap) begin
                break;
            end
            opts = {opts, CAPA_PARAM_TYPE, 8'(caps.size()), caps};
        end
        if (opts.size() == 0) begin
            opts = {CAPA_PARAM_TYPE, 8'd2, SKIP_CODE, 8'd0};
        end
        asn2 = ($urandom_range(0, 9) < 3) ? ASN_TRANSITION[15:0] : 16'($urandom);
        put_header(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd4, asn2,
                   16'($urandom), $urandom, 8'(opts.size()));
        body_q = {body_q, opts};
    endtask

    // stimulus
    initial begin
        int unsigned pick;
        int unsigned pos;
        logic [11:0] len;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest clean message, header fields all zero, zero-length capability
        put_header(8'h00, 16'h0000, 16'h0000, 32'h0, 8'd4);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd2, SKIP_CODE, 8'd0};
        send_body(body_len, 1'b0);
        // header fields all ones, skipped capability of ones
        put_header(8'hff, 16'hffff, 16'hffff, 32'hffff_ffff, 8'd8);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd6, 8'hff, 8'd4, 8'hff, 8'hff, 8'hff, 8'hff};
        send_body(body_len, 1'b0);
        // large four-byte asn behind the transition asn
        put_header(8'd4, ASN_TRANSITION[15:0], 16'd90, 32'h0a0b_0c0d, 8'd8);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd6, ASN4_CODE, ASN4_LEN,
                  8'hff, 8'hff, 8'hff, 8'hff};
        send_body(body_len, 1'b0);
        // four-byte asn at the limit without the transition asn
        put_header(8'd4, 16'h1234, 16'd180, 32'h0102_0304, 8'd8);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd6, ASN4_CODE, ASN4_LEN,
                  8'h00, 8'h00, 8'hff, 8'hff};
        send_body(body_len, 1'b0);
        // four-byte asn capability with the wrong length
        put_header(8'd4, 16'h0042, 16'd3, 32'h0, 8'd6);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd4, ASN4_CODE, 8'd2, 8'h12, 8'h34};
        send_body(body_len, 1'b0);
        // message length below the header length
        build_open(20);
        send_body(12'd5, 1'b0);
        // optional length disagrees with the message length
        build_open(20);
        send_body(body_len + 12'd1, 1'b0);
        // optional length below two
        put_header(8'd4, 16'd1, 16'd1, 32'd1, 8'd1);
        body_q = {body_q, 8'h00};
        send_body(body_len, 1'b0);
        // parameter other than capabilities
        put_header(8'd4, 16'd2, 16'd2, 32'd2, 8'd4);
        body_q = {body_q, 8'd3, 8'd2, SKIP_CODE, 8'd0};
        send_body(body_len, 1'b0);
        // parameter longer than what is left
        put_header(8'd4, 16'd3, 16'd3, 32'd3, 8'd4);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd3, SKIP_CODE, 8'd0};
        send_body(body_len, 1'b0);
        // parameter length of one
        put_header(8'd4, 16'd4, 16'd4, 32'd4, 8'd3);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd1, 8'd0};
        send_body(body_len, 1'b0);
        // capability longer than its parameter
        put_header(8'd4, 16'd5, 16'd5, 32'd5, 8'd4);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd2, SKIP_CODE, 8'd1};
        send_body(body_len, 1'b0);
        // one stray byte left in the parameter
        put_header(8'd4, 16'd6, 16'd6, 32'd6, 8'd5);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd3, SKIP_CODE, 8'd0, 8'd0};
        send_body(body_len, 1'b0);
        // one stray byte left in the optional parameters
        put_header(8'd4, 16'd7, 16'd7, 32'd7, 8'd5);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd2, SKIP_CODE, 8'd0, 8'd0};
        send_body(body_len, 1'b0);
        // early end inside the parameters, then inside the header
        build_open(30);
        while (body_q.size() > 12) void'(body_q.pop_back());
        send_body(body_len, 1'b0);
        build_open(30);
        while (body_q.size() > 5) void'(body_q.pop_back());
        send_body(body_len, 1'b0);
        // extra byte after a complete message
        build_open(30);
        body_q = {body_q, 8'($urandom)};
        send_body(body_len, 1'b0);
        // longest optional part
        put_header(8'd4, 16'($urandom), 16'($urandom), $urandom, 8'd255);
        body_q = {body_q, CAPA_PARAM_TYPE, 8'd253, SKIP_CODE, 8'd251};
        repeat (251) body_q = {body_q, 8'($urandom)};
        send_body(body_len, 1'b0);
        // single item message at the largest length
        body_q = {8'h5a};
        send_body(12'hfff, 1'b0);

        wait_drained();

        // random messages, mostly well formed, some damaged, some noise
        while (bytes_sent < 700 || msgs_sent < 25) begin
            quiet = ($urandom_range(0, 7) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 10) begin
                body_q = {};
                repeat ($urandom_range(1, 24)) body_q = {body_q, 8'($urandom)};
                send_body(12'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                build_open(($urandom_range(0, 14) == 0) ? $urandom_range(100, 255)
                                                         : $urandom_range(4, 40));
                len = body_len;
                if (pick >= 60 && pick < 70) begin
                    pos = $urandom_range(9, body_q.size() - 1);
                    body_q[pos] = 8'($urandom);
                end else if (pick >= 70 && pick < 75) begin
                    pos = $urandom_range(0, body_q.size() - 1);
                    body_q[pos] = 8'($urandom);
                end else if (pick >= 75 && pick < 80) begin
                    pos = $urandom_range(1, body_q.size() - 1);
                    while (body_q.size() > pos) void'(body_q.pop_back());
                end else if (pick >= 80 && pick < 85) begin
                    repeat ($urandom_range(1, 3)) body_q = {body_q, 8'($urandom)};
                end else if (pick >= 85 && pick < 90) begin
                    len = 12'($urandom);
                end else if (pick >= 90 && pick < 95) begin
                    len = 12'($urandom_range(0, 9));
                end else if (pick >= 95) begin
                    body_q[10] = 8'($urandom);
                end
                send_body(len, 1'b0);
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end

        // drain and finish
        quiet = 1'b0;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bgpop_pkg.sv
rtl/core/bgpop_engine.sv
rtl/core/bgp_open_message_parser.sv
dv/tb.sv
